[rtl/text_console_writer_defines.svh]
// assertion macros shared by the rtl

`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// same-cycle implication, checked once reset is released
`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("console writer check failed");

// next-cycle implication, checked once reset is released
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("console writer check failed");

`endif

[rtl/tcw_pkg.sv]
package tcw_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ATTR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_ATTR   = 2'd1;

	localparam logic [7:0] RESET_DEFAULT_ATTR = 8'd15;
	localparam logic [7:0] RESET_ERROR_ATTR   = 8'd244;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] BLANK_CODE   = 8'd32;
	localparam logic [7:0] ERROR_CODE   = 8'd69;

	typedef enum logic [2:0] {
		KIND_PUT_CURSOR   = 3'd0,
		KIND_PUT_POS      = 3'd1,
		KIND_BACKSPACE    = 3'd2,
		KIND_CLEAR_ROW    = 3'd3,
		KIND_CLEAR_SCREEN = 3'd4,
		KIND_READ         = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SCROLL,
		ST_DRAIN,
		ST_FILL
	} state_t;

	typedef struct packed {
		logic [7:0] at;
		logic [7:0] ch;
	} cell_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] char_code;
		logic [7:0] attr;
		logic [6:0] column;
		logic [4:0] row;
	} cmd_t;

	typedef struct packed {
		logic [4:0] cursor_row;
		logic [6:0] cursor_col;
		logic [7:0] cell_char;
		logic [7:0] cell_attr;
		logic       off_screen;
		logic       scrolled;
	} result_t;

endpackage

[rtl/tcw_screen_ram.sv]
module tcw_screen_ram import tcw_pkg::*; #(
	parameter int DEPTH = DEF_COLUMNS * DEF_ROWS,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  cell_t         wr_cell,
	input  logic [AW-1:0] rd_addr,
	output cell_t         rd_cell
);

	cell_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_cell;
		end
	end

	always_ff @(posedge clk) begin
		rd_cell <= mem[rd_addr];
	end

endmodule

[rtl/tcw_engine.sv]
module tcw_engine import tcw_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS,
	localparam int CELLS  = COLUMNS * ROWS,
	localparam int AW     = $clog2(CELLS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  cmd_t          cmd,
	input  logic [7:0]    default_attr,
	input  logic [7:0]    error_attr,
	output logic          done,
	output result_t       result,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output cell_t         wr_cell,
	output logic [AW-1:0] rd_addr,
	input  cell_t         rd_cell
);

	localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
	localparam logic [AW-1:0] COLS_M1_A  = AW'(COLUMNS - 1);
	localparam logic [AW-1:0] LAST_A     = AW'(CELLS - 1);
	localparam logic [AW-1:0] BOT_A      = AW'(CELLS - COLUMNS);
	localparam logic [AW-1:0] SCR_LAST_A = AW'(CELLS - COLUMNS - 1);
	localparam logic [7:0]    COL_LIM    = 8'(COLUMNS);
	localparam logic [5:0]    ROW_LIM    = 6'(ROWS);
	localparam logic [6:0]    COL_LAST   = 7'(COLUMNS - 1);
	localparam logic [4:0]    ROW_LAST   = 5'(ROWS - 1);

	state_t        state_q, state_d;
	logic [AW-1:0] idx_q, end_q, cp_addr_q, pos_q, pos_d;
	logic          cp_vld_q;
	logic [4:0]    cur_row_q, prow_q, trow;
	logic [6:0]    cur_col_q, pcol_q, tcol;
	logic [2:0]    kind_q;
	logic [7:0]    char_q, attr_q;
	logic          on_q, on_screen;
	logic          done_q, off_q, scr_q;
	logic [7:0]    rchar_q, rattr_q;
	logic          nl, wrap, need_scroll;
	logic [7:0]    col_inc;
	logic [5:0]    row_inc;

	// target position of the incoming transaction
	always_comb begin
		trow = '0;
		tcol = '0;
		case (cmd.kind)
			KIND_PUT_CURSOR: begin
				trow = cur_row_q;
				tcol = cur_col_q;
			end
			KIND_PUT_POS, KIND_READ: begin
				trow = cmd.row;
				tcol = cmd.column;
			end
			KIND_BACKSPACE: begin
				if (cur_col_q != 7'd0) begin
					trow = cur_row_q;
					tcol = cur_col_q - 7'd1;
				end else if (cur_row_q != 5'd0) begin
					trow = cur_row_q - 5'd1;
					tcol = COL_LAST;
				end
			end
			KIND_CLEAR_ROW: begin
				trow = cur_row_q;
			end
			default: begin
				trow = '0;
				tcol = '0;
			end
		endcase
	end

	assign pos_d     = AW'(trow) * COLS_A + AW'(tcol);
	assign on_screen = ({1'b0, cmd.column} < COL_LIM) && ({1'b0, cmd.row} < ROW_LIM);

	assign nl          = (char_q == NEWLINE_CODE);
	assign col_inc     = {1'b0, pcol_q} + 8'd1;
	assign row_inc     = {1'b0, prow_q} + 6'd1;
	assign wrap        = nl || (col_inc == COL_LIM);
	assign need_scroll = wrap && (row_inc == ROW_LIM);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (idx_q == LAST_A) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (kind_q)
					KIND_PUT_CURSOR, KIND_PUT_POS: begin
						state_d = (on_q && need_scroll) ? ST_SCROLL : ST_IDLE;
					end
					KIND_CLEAR_ROW, KIND_CLEAR_SCREEN: state_d = ST_FILL;
					KIND_READ: state_d = on_q ? ST_READ : ST_IDLE;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_READ: state_d = ST_IDLE;
			ST_SCROLL: begin
				if (idx_q == SCR_LAST_A) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_FILL;
			ST_FILL: begin
				if (idx_q == end_q) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_cell = '{at: default_attr, ch: BLANK_CODE};
		rd_addr = pos_q;
		busy    = (state_q != ST_IDLE);
		case (state_q)
			ST_INIT: begin
				wr_en   = 1'b1;
				wr_cell = '{at: RESET_DEFAULT_ATTR, ch: BLANK_CODE};
			end
			ST_EXEC: begin
				if (kind_q inside {KIND_PUT_CURSOR, KIND_PUT_POS}) begin
					if (!on_q) begin
						wr_en   = 1'b1;
						wr_addr = LAST_A;
						wr_cell = '{at: error_attr, ch: ERROR_CODE};
					end else if (!nl) begin
						wr_en   = 1'b1;
						wr_addr = pos_q;
						wr_cell = '{at: attr_q, ch: char_q};
					end
				end else if (kind_q == KIND_BACKSPACE) begin
					wr_en   = 1'b1;
					wr_addr = pos_q;
				end
			end
			ST_SCROLL: begin
				rd_addr = idx_q + COLS_A;
				wr_en   = cp_vld_q;
				wr_addr = cp_addr_q;
				wr_cell = rd_cell;
			end
			ST_DRAIN: begin
				wr_en   = 1'b1;
				wr_addr = cp_addr_q;
				wr_cell = rd_cell;
			end
			ST_FILL: begin
				wr_en = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			idx_q     <= '0;
			end_q     <= '0;
			cp_addr_q <= '0;
			cp_vld_q  <= 1'b0;
			pos_q     <= '0;
			cur_row_q <= '0;
			cur_col_q <= '0;
			prow_q    <= '0;
			pcol_q    <= '0;
			kind_q    <= '0;
			char_q    <= '0;
			attr_q    <= '0;
			on_q      <= 1'b0;
			done_q    <= 1'b0;
			off_q     <= 1'b0;
			scr_q     <= 1'b0;
			rchar_q   <= '0;
			rattr_q   <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_d == ST_IDLE) && (state_q != ST_IDLE) && (state_q != ST_INIT);
			case (state_q)
				ST_INIT: begin
					idx_q <= (idx_q == LAST_A) ? '0 : idx_q + 1'b1;
				end
				ST_IDLE: begin
					if (start) begin
						kind_q  <= cmd.kind;
						char_q  <= cmd.char_code;
						attr_q  <= (cmd.attr == 8'd0) ? default_attr : cmd.attr;
						on_q    <= (cmd.kind == KIND_PUT_CURSOR) ? 1'b1 : on_screen;
						prow_q  <= trow;
						pcol_q  <= tcol;
						pos_q   <= pos_d;
						off_q   <= 1'b0;
						scr_q   <= 1'b0;
						rchar_q <= '0;
						rattr_q <= '0;
					end
				end
				ST_EXEC: begin
					case (kind_q)
						KIND_PUT_CURSOR, KIND_PUT_POS: begin
							if (!on_q) begin
								off_q <= 1'b1;
							end else if (need_scroll) begin
								idx_q     <= '0;
								cp_vld_q  <= 1'b0;
								scr_q     <= 1'b1;
								cur_row_q <= ROW_LAST;
								cur_col_q <= '0;
							end else if (wrap) begin
								cur_row_q <= row_inc[4:0];
								cur_col_q <= '0;
							end else begin
								cur_row_q <= prow_q;
								cur_col_q <= col_inc[6:0];
							end
						end
						KIND_BACKSPACE: begin
							cur_row_q <= prow_q;
							cur_col_q <= pcol_q;
						end
						KIND_CLEAR_ROW: begin
							idx_q     <= pos_q;
							end_q     <= pos_q + COLS_M1_A;
							cur_row_q <= prow_q;
							cur_col_q <= '0;
						end
						KIND_CLEAR_SCREEN: begin
							idx_q     <= '0;
							end_q     <= LAST_A;
							cur_row_q <= '0;
							cur_col_q <= '0;
						end
						default: begin
							idx_q <= idx_q;
						end
					endcase
				end
				ST_READ: begin
					rchar_q <= rd_cell.ch;
					rattr_q <= rd_cell.at;
				end
				ST_SCROLL: begin
					cp_addr_q <= idx_q;
					cp_vld_q  <= 1'b1;
					idx_q     <= idx_q + 1'b1;
				end
				ST_DRAIN: begin
					cp_vld_q <= 1'b0;
					idx_q    <= BOT_A;
					end_q    <= LAST_A;
				end
				ST_FILL: begin
					idx_q <= idx_q + 1'b1;
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	assign done              = done_q;
	assign result.cursor_row = cur_row_q;
	assign result.cursor_col = cur_col_q;
	assign result.cell_char  = rchar_q;
	assign result.cell_attr  = rattr_q;
	assign result.off_screen = off_q;
	assign result.scrolled   = scr_q;

endmodule

[rtl/text_console_writer.sv]
// channel   | signals                                   | direction | transaction when
// ----------+-------------------------------------------+-----------+------------------------
// command   | start, busy, cmd                          | in        | start && !busy
// result    | done, result                              | out       | done (one cycle)
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | in        | cfg_valid && cfg_ready
//
// a character write, backspace or read goes through the screen ram, which has one write port and one read port
// clear row blanks the cursor row and clear screen blanks the whole screen, one cell per cycle
// a scroll copies each cell up by one row, one cell per cycle, then blanks the bottom row
// after reset the screen is blanked with busy high
// config is always ready; results cannot be stalled and appear as a one-cycle done pulse

`include "text_console_writer_defines.svh"

module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cmd_t                 cmd,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);

	logic [7:0]    default_attr_q, error_attr_q;
	logic          wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	cell_t         wr_cell, rd_cell;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_attr_q <= RESET_DEFAULT_ATTR;
			error_attr_q   <= RESET_ERROR_ATTR;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEFAULT_ATTR: default_attr_q <= cfg_data;
				REG_ERROR_ATTR:   error_attr_q   <= cfg_data;
				default:          default_attr_q <= default_attr_q;
			endcase
		end
	end

	tcw_engine #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.default_attr (default_attr_q),
		.error_attr   (error_attr_q),
		.done         (done),
		.result       (result),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_cell      (wr_cell),
		.rd_addr      (rd_addr),
		.rd_cell      (rd_cell)
	);

	tcw_screen_ram #(
		.DEPTH (CELLS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_cell (wr_cell),
		.rd_addr (rd_addr),
		.rd_cell (rd_cell)
	);

	`TCW_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`TCW_ASSERT_NEXT(a_single_done, clk, arst_n, done, !done)
	`TCW_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy)
	`TCW_ASSERT_NOW(a_cursor_range, clk, arst_n, done, ({1'b0, result.cursor_col} < 8'(COLUMNS)) && ({1'b0, result.cursor_row} < 6'(ROWS)))
	`TCW_ASSERT_NOW(a_off_no_scroll, clk, arst_n, done, !(result.off_screen && result.scrolled))

endmodule
